// ===== hw/rtl/sdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpg_pkg
// Types, field widths and constants shared by the step/direction generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
	localparam int unsigned QUEUE_DEPTH_DEF      = 2;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int SPEED_W  = 18;
	localparam int PERIOD_W = 16;

	localparam logic [SPEED_W-1:0]  SPEED_MIN  = 18'd20;
	localparam logic [SPEED_W-1:0]  SPEED_MAX  = 18'd250000;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'd65535;
	localparam int unsigned         RESET_SPEED = 1000;

	localparam int APB_ADDR_W = 1;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_INVERT_DIR = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 3'd0,
		KIND_REL       = 3'd1,
		KIND_ABS       = 3'd2,
		KIND_RUN       = 3'd3,
		KIND_STOP      = 3'd4,
		KIND_SET_SPEED = 3'd5,
		KIND_SET_POS   = 3'd6
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		logic [SPEED_W-1:0]        speed;
		logic                      forward;
	} cmd_t;

	typedef struct packed {
		logic                      step_level;
		logic                      dir_level;
		logic signed [VALUE_W-1:0] position;
		logic signed [VALUE_W-1:0] target_position;
		logic                      running;
		logic                      continuous;
	} res_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [VALUE_W-1:0]  value;
		logic [PERIOD_W-1:0] period;
		logic                forward;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hw/rtl/sdpg_stream_if.sv =====
// ----------------------------------------------------------------------------
// sdpg_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sdpg_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sdpg_front.sv =====
// ----------------------------------------------------------------------------
// sdpg_front
// Accepts commands, turns speed into a period with a restoring divider and
// pushes classified entries into the command queue.
// ----------------------------------------------------------------------------
module sdpg_front import sdpg_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sdpg_stream_if.sink          cmd,
	output logic                 push,
	output entry_t               push_entry,
	input  q_status_t            q_status
);

	localparam int DIV_W = $clog2(TICKS_PER_SECOND + 1);
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int QW    = (DIV_W > PERIOD_W + 1) ? DIV_W : PERIOD_W + 1;
	localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICKS_PER_SECOND);

	typedef enum logic {
		F_IDLE,
		F_DIV
	} f_state_t;

	f_state_t                state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIV_W-1:0]        dvd_q;
	logic [DIV_W-1:0]        quot_q;
	logic [SPEED_W-1:0]      rem_q;
	logic [SPEED_W-1:0]      divisor_q;
	logic [KIND_W-1:0]       kind_q;
	logic [VALUE_W-1:0]      value_q;
	logic                    forward_q;

	logic                    accept;
	logic                    is_speed;
	logic                    last;
	logic [SPEED_W-1:0]      speed_clamp;
	logic [SPEED_W:0]        rem_sh;
	logic [SPEED_W:0]        diff;
	logic                    take;
	logic [DIV_W-1:0]        quot_next;
	logic [SPEED_W-1:0]      rem_next;
	logic [QW-1:0]           quot_ext;
	logic [PERIOD_W-1:0]     period;

	assign cmd.ready = (state_q == F_IDLE) && !q_status.full;
	assign accept    = cmd.valid && cmd.ready;
	assign is_speed  = (cmd.data.kind == KIND_RUN) || (cmd.data.kind == KIND_SET_SPEED);

	always_comb begin
		if (cmd.data.speed < SPEED_MIN) begin
			speed_clamp = SPEED_MIN;
		end else if (cmd.data.speed > SPEED_MAX) begin
			speed_clamp = SPEED_MAX;
		end else begin
			speed_clamp = cmd.data.speed;
		end
	end

	// one quotient bit per cycle
	assign rem_sh    = {rem_q, dvd_q[DIV_W-1]};
	assign diff      = rem_sh - {1'b0, divisor_q};
	assign take      = !diff[SPEED_W];
	assign quot_next = {quot_q[DIV_W-2:0], take};
	assign rem_next  = take ? diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
	assign last      = (cnt_q == CNT_W'(DIV_W - 1));
	assign quot_ext  = QW'(quot_next);

	always_comb begin
		if (quot_ext > QW'(PERIOD_MAX)) begin
			period = PERIOD_MAX;
		end else if (quot_ext < QW'(PERIOD_MIN)) begin
			period = PERIOD_MIN;
		end else begin
			period = quot_ext[PERIOD_W-1:0];
		end
	end

	assign push = (accept && !is_speed) || ((state_q == F_DIV) && last);

	always_comb begin
		if (state_q == F_DIV) begin
			push_entry.kind    = kind_q;
			push_entry.value   = value_q;
			push_entry.period  = period;
			push_entry.forward = forward_q;
		end else begin
			push_entry.kind    = cmd.data.kind;
			push_entry.value   = cmd.data.value;
			push_entry.period  = PERIOD_MIN;
			push_entry.forward = cmd.data.forward;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && is_speed) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= cmd.data.kind;
			value_q   <= cmd.data.value;
			forward_q <= cmd.data.forward;
			divisor_q <= speed_clamp;
			dvd_q     <= DIVIDEND;
			rem_q     <= '0;
			quot_q    <= '0;
		end else if (state_q == F_DIV) begin
			dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q  <= rem_next;
			quot_q <= quot_next;
		end
	end

	a_no_accept_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> !cmd.ready)
		else $error("command accepted during division");

	a_div_push_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == F_DIV) && last) |=> (state_q == F_IDLE))
		else $error("divider did not finish");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

endmodule

// ===== hw/rtl/sdpg_queue.sv =====
// ----------------------------------------------------------------------------
// sdpg_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module sdpg_queue import sdpg_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	output q_status_t q_status,
	input  logic      pop,
	output entry_t    pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign q_status.full  = (count_q == CNT_W'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_entry      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_status.full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("queue underflow");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

// ===== hw/rtl/sdpg_back.sv =====
// ----------------------------------------------------------------------------
// sdpg_back
// Executes queued commands on the stepper state and registers the result.
// ----------------------------------------------------------------------------
module sdpg_back import sdpg_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       invert_dir,
	input  q_status_t  q_status,
	output logic       pop,
	input  entry_t     pop_entry,
	sdpg_stream_if.source res
);

	localparam int unsigned RAW_PERIOD = TICKS_PER_SECOND / RESET_SPEED;
	localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(
		(RAW_PERIOD < 2) ? 2 : ((RAW_PERIOD > 65535) ? 65535 : RAW_PERIOD));

	logic [VALUE_W-1:0]  pos_q, pos_n;
	logic [VALUE_W-1:0]  goal_q, goal_n;
	logic                run_q, run_n;
	logic                cont_q, cont_n;
	logic                fwd_q, fwd_n;
	logic [PERIOD_W-1:0] pc_q, pc_n;
	logic [PERIOD_W-1:0] act_q, act_n;
	logic [PERIOD_W-1:0] pend_q, pend_n;
	logic                pulse_q, pulse_n;
	logic                sp_q, sp_n;
	logic                out_valid_q;
	res_t                res_q;

	logic                begin_run;
	logic                pc_zero;
	logic [PERIOD_W-1:0] pc_inc;
	logic [VALUE_W-1:0]  pos_step;
	logic [VALUE_W-1:0]  reach_inc;
	logic [VALUE_W-1:0]  reach_diff;
	logic                reached;
	logic [VALUE_W-1:0]  rel_goal;
	logic [VALUE_W-1:0]  abs_count;

	assign pop = !q_status.empty && (!out_valid_q || res.ready);

	assign pc_zero  = (pc_q == '0);
	assign pc_inc   = pc_q + 1'b1;
	assign pos_step = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;
	// goal minus the position after this tick, in one adder
	assign reach_inc  = pc_zero ? (fwd_q ? VALUE_W'(0) : VALUE_W'(2)) : VALUE_W'(1);
	assign reach_diff = goal_q + ~pos_q + reach_inc;
	assign reached    = fwd_q ? (reach_diff[VALUE_W-1] || (reach_diff == '0))
	                          : !reach_diff[VALUE_W-1];
	assign rel_goal   = pos_q + pop_entry.value;
	assign abs_count  = pop_entry.value - pos_q;

	always_comb begin
		pos_n     = pos_q;
		goal_n    = goal_q;
		run_n     = run_q;
		cont_n    = cont_q;
		fwd_n     = fwd_q;
		pc_n      = pc_q;
		act_n     = act_q;
		pend_n    = pend_q;
		pulse_n   = pulse_q;
		sp_n      = sp_q;
		begin_run = 1'b0;
		unique case (pop_entry.kind)
			KIND_TICK: begin
				if (run_q) begin
					if (pc_zero) begin
						act_n   = pend_q;
						pulse_n = 1'b1;
						pos_n   = pos_step;
					end
					pc_n = pc_inc;
					if (pc_inc == (act_n >> 1)) begin
						pulse_n = 1'b0;
					end
					if (!cont_q && !sp_q && reached) begin
						sp_n = 1'b1;
					end
					if (pc_inc >= act_n) begin
						pc_n = '0;
						if (sp_n) begin
							run_n = 1'b0;
							sp_n  = 1'b0;
						end
					end
				end
			end
			KIND_REL: begin
				if (pop_entry.value != '0) begin
					fwd_n     = !pop_entry.value[VALUE_W-1];
					goal_n    = rel_goal;
					cont_n    = 1'b0;
					begin_run = 1'b1;
				end
			end
			KIND_ABS: begin
				if (abs_count != '0) begin
					fwd_n     = !abs_count[VALUE_W-1];
					goal_n    = pop_entry.value;
					cont_n    = 1'b0;
					begin_run = 1'b1;
				end
			end
			KIND_RUN: begin
				fwd_n     = pop_entry.forward;
				pend_n    = pop_entry.period;
				cont_n    = 1'b1;
				begin_run = 1'b1;
			end
			KIND_STOP: begin
				cont_n = 1'b0;
				if (run_q) begin
					sp_n = 1'b1;
				end
			end
			KIND_SET_SPEED: pend_n = pop_entry.period;
			KIND_SET_POS:   pos_n  = pop_entry.value;
			default: ;
		endcase
		if (begin_run) begin
			if (!run_q) begin
				pc_n    = '0;
				pulse_n = 1'b0;
			end
			run_n = 1'b1;
			sp_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			goal_q      <= '0;
			run_q       <= 1'b0;
			cont_q      <= 1'b0;
			fwd_q       <= 1'b1;
			pc_q        <= '0;
			act_q       <= RESET_PERIOD;
			pend_q      <= RESET_PERIOD;
			pulse_q     <= 1'b0;
			sp_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q       <= pos_n;
				goal_q      <= goal_n;
				run_q       <= run_n;
				cont_q      <= cont_n;
				fwd_q       <= fwd_n;
				pc_q        <= pc_n;
				act_q       <= act_n;
				pend_q      <= pend_n;
				pulse_q     <= pulse_n;
				sp_q        <= sp_n;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.step_level      <= pulse_n;
			res_q.dir_level       <= invert_dir ^ !fwd_n;
			res_q.position        <= pos_n;
			res_q.target_position <= goal_n;
			res_q.running         <= run_n;
			res_q.continuous      <= cont_n;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	a_idle_pulse_low: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> !pulse_q)
		else $error("step output high while idle");

	a_stop_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q |-> run_q)
		else $error("stop pending while idle");

	a_cont_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		cont_q |-> run_q)
		else $error("continuous flag while idle");

	a_counter_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q < act_q)
		else $error("period counter past active period");

endmodule

// ===== hw/rtl/step_dir_pulse_generator_unit.sv =====
// ----------------------------------------------------------------------------
// step_dir_pulse_generator_unit
// Step/direction pulse generator with APB direction setting.
// ----------------------------------------------------------------------------
// channel  dir  payload  transaction
// cmd      in   cmd_t    cmd.valid && cmd.ready
// res      out  res_t    res.valid && res.ready
// apb      in   32 bit   psel && penable && pwrite (single register)
//
// tick, move, stop and set position commands enter the queue when accepted
// run and set speed are pushed once the front divider has made the period
// unless res stalls, the back executes one queued command per cycle into the
// output register; asynchronous reset, no clearing pass; each side stalls alone
module step_dir_pulse_generator_unit import sdpg_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
	parameter int unsigned QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	sdpg_stream_if.sink           cmd,
	sdpg_stream_if.source         res
);

	logic      invert_dir_q;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    pop_entry;
	q_status_t q_status;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_INVERT_DIR) ? {{(APB_DATA_W-1){1'b0}}, invert_dir_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_dir_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_INVERT_DIR)) begin
			invert_dir_q <= pwdata[0];
		end
	end

	sdpg_front #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_entry(push_entry),
		.q_status  (q_status)
	);

	sdpg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.q_status  (q_status),
		.pop       (pop),
		.pop_entry (pop_entry)
	);

	sdpg_back #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.invert_dir(invert_dir_q),
		.q_status  (q_status),
		.pop       (pop),
		.pop_entry (pop_entry),
		.res       (res)
	);

endmodule

// ===== verif/step_dir_pulse_generator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_dir_pulse_generator_unit_tb
// Self-checking bench for the step/direction generator. Commands go in on the
// cmd channel and each one returns a status word on the res channel. A
// tracker class mirrors the tick-driven pulse timing, position counting and
// goal handling, and compares every status field in order. A directed opener
// covers clamps, wraparound and ignored moves. Random move, run and noise
// sequences follow, with stalls on both sides, a long output hold-off and
// direction inversion changes over APB.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator_unit_tb;
	import sdpg_pkg::*;

	localparam int N_ITEMS        = 1550;
	localparam int QUIET_AT       = 1380;
	localparam int HOLD_AT        = 600;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	class pulse_tracker;
		bit          invert_dir;
		logic [31:0] step_pos;
		logic [31:0] goal_pos;
		bit          busy;
		bit          free_run;
		bit          going_fwd;
		bit          step_hi;
		bit          halt_req;
		int unsigned tick_cnt;
		int unsigned live_period;
		int unsigned next_period;
		res_t        status_q[$];
		int          errors;

		function new();
			invert_dir  = 1'b0;
			step_pos    = '0;
			goal_pos    = '0;
			busy        = 1'b0;
			free_run    = 1'b0;
			going_fwd   = 1'b1;
			step_hi     = 1'b0;
			halt_req    = 1'b0;
			tick_cnt    = 0;
			live_period = period_of(RESET_SPEED);
			next_period = live_period;
			errors      = 0;
		endfunction

		function int unsigned period_of(int unsigned sp);
			int unsigned s;
			int unsigned p;
			s = sp;
			if (s < SPEED_MIN) s = SPEED_MIN;
			if (s > SPEED_MAX) s = SPEED_MAX;
			p = TICKS_PER_SECOND_DEF / s;
			if (p < PERIOD_MIN) p = PERIOD_MIN;
			if (p > PERIOD_MAX) p = PERIOD_MAX;
			return p;
		endfunction

		function void start_run();
			if (!busy) begin
				tick_cnt = 0;
				step_hi  = 1'b0;
			end
			busy     = 1'b1;
			halt_req = 1'b0;
		endfunction

		function void start_move(logic [31:0] steps);
			if (steps == 0) return;
			going_fwd = !steps[31];
			goal_pos  = step_pos + steps;
			free_run  = 1'b0;
			start_run();
		endfunction

		function bit goal_hit();
			logic [31:0] d;
			d = goal_pos - step_pos;
			if (going_fwd) return d[31] || d == 0;
			return !d[31];
		endfunction

		function void advance();
			if (!busy) return;
			if (tick_cnt == 0) begin
				live_period = next_period;
				step_hi     = 1'b1;
				step_pos    = going_fwd ? step_pos + 1 : step_pos - 1;
			end
			tick_cnt++;
			if (tick_cnt == live_period / 2) step_hi = 1'b0;
			if (!free_run && !halt_req && goal_hit()) halt_req = 1'b1;
			if (tick_cnt >= live_period) begin
				tick_cnt = 0;
				if (halt_req) begin
					busy     = 1'b0;
					halt_req = 1'b0;
				end
			end
		endfunction

		function void take_cmd(cmd_t c);
			res_t r;
			case (c.kind)
				KIND_TICK:      advance();
				KIND_REL:       start_move(c.value);
				KIND_ABS:       start_move(c.value - step_pos);
				KIND_RUN: begin
					going_fwd   = c.forward;
					next_period = period_of(c.speed);
					free_run    = 1'b1;
					start_run();
				end
				KIND_STOP: begin
					free_run = 1'b0;
					if (busy) halt_req = 1'b1;
				end
				KIND_SET_SPEED: next_period = period_of(c.speed);
				KIND_SET_POS:   step_pos = c.value;
				default: ;
			endcase
			r.step_level      = step_hi;
			r.dir_level       = going_fwd ? invert_dir : !invert_dir;
			r.position        = step_pos;
			r.target_position = goal_pos;
			r.running         = busy;
			r.continuous      = free_run;
			status_q.push_back(r);
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_status(res_t got);
			res_t want;
			if (status_q.size() == 0) begin
				$error("status transaction with nothing expected: %0h", got);
				errors++;
				return;
			end
			want = status_q.pop_front();
			cmp("step_level", want.step_level, got.step_level);
			cmp("dir_level", want.dir_level, got.dir_level);
			cmp("position", want.position, got.position);
			cmp("target_position", want.target_position, got.target_position);
			cmp("running", want.running, got.running);
			cmp("continuous", want.continuous, got.continuous);
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sdpg_stream_if #(.T(cmd_t)) cmd_ch ();
	sdpg_stream_if #(.T(res_t)) res_ch ();

	pulse_tracker trk;
	int           sent = 0;
	int           quiet_cycles = 0;
	bit           idle_on;
	bit           hold_req;

	step_dir_pulse_generator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.res     (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic cmd_t mk(logic [KIND_W-1:0] k, logic [31:0] v, logic [SPEED_W-1:0] sp,
			logic f);
		cmd_t c;
		c.kind    = k;
		c.value   = v;
		c.speed   = sp;
		c.forward = f;
		return c;
	endfunction

	function automatic cmd_t rnd_cmd(logic [KIND_W-1:0] k);
		return mk(k, $urandom, $urandom_range(0, 262143), $urandom_range(0, 1));
	endfunction

	function automatic logic [SPEED_W-1:0] fast_speed();
		if ($urandom_range(0, 9) < 7) return $urandom_range(50000, 262143);
		return $urandom_range(10000, 50000);
	endfunction

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(0, 2))
			0:       return $urandom;
			1:       return 32'h7FFF_FFF8 + $urandom_range(0, 15);
			default: return $urandom_range(0, 15) - 8;
		endcase
	endfunction

	task automatic send(input cmd_t c);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		trk.take_cmd(c);
		sent++;
	endtask

	task automatic ticks_until_idle(input int cap);
		int k;
		k = 0;
		while (trk.busy && k < cap) begin
			send(rnd_cmd(KIND_TICK));
			k++;
		end
	endtask

	task automatic settle();
		if (trk.busy) begin
			send(rnd_cmd(KIND_STOP));
			ticks_until_idle(200);
		end
	endtask

	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		while (trk.pending() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		trk.invert_dir = d[0];
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("prdata: expected %0h, actual %0h", want, prdata);
			trk.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_invert(input bit v);
		wait_drain();
		apb_write(ADDR_INVERT_DIR, {31'b0, v});
		@(posedge clk);
		apb_read(ADDR_INVERT_DIR, {31'b0, v});
	endtask

	task automatic move_seq();
		int          k;
		int          steps;
		logic [31:0] near;
		if ($urandom_range(0, 2) == 0)
			send(mk(KIND_SET_SPEED, $urandom, fast_speed(), $urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			send(mk(KIND_SET_POS, pick_pos(), $urandom_range(0, 262143), $urandom_range(0, 1)));
		steps = $urandom_range(1, 12);
		if ($urandom_range(0, 1)) steps = -steps;
		case ($urandom_range(0, 5))
			0, 1, 2: send(mk(KIND_REL, steps, $urandom_range(0, 262143), $urandom_range(0, 1)));
			3, 4: send(mk(KIND_ABS, trk.step_pos + steps, $urandom_range(0, 262143),
				$urandom_range(0, 1)));
			default: begin
				if ($urandom_range(0, 1))
					send(mk(KIND_ABS, trk.step_pos, $urandom, $urandom_range(0, 1)));
				else
					send(mk(KIND_REL, 0, $urandom, $urandom_range(0, 1)));
				send(mk(KIND_REL, steps, $urandom, $urandom_range(0, 1)));
			end
		endcase
		k = 0;
		while (trk.busy && k < 300) begin
			near = trk.step_pos + $urandom_range(0, 8) - 4;
			case ($urandom_range(0, 49))
				0: send(rnd_cmd(KIND_STOP));
				1: send(mk(KIND_SET_SPEED, $urandom, fast_speed(), $urandom_range(0, 1)));
				2: send(mk(KIND_SET_POS, near, $urandom, $urandom_range(0, 1)));
				3: send(mk(KIND_REL, $urandom_range(0, 10) - 5, $urandom, $urandom_range(0, 1)));
				default: send(rnd_cmd(KIND_TICK));
			endcase
			k++;
		end
		settle();
	endtask

	task automatic run_seq();
		int n;
		send(mk(KIND_RUN, $urandom, fast_speed(), $urandom_range(0, 1)));
		n = $urandom_range(5, 40);
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: send(mk(KIND_RUN, $urandom, fast_speed(), $urandom_range(0, 1)));
				1: send(mk(KIND_SET_SPEED, $urandom, fast_speed(), $urandom_range(0, 1)));
				2: send(mk(KIND_SET_POS, pick_pos(), $urandom, $urandom_range(0, 1)));
				default: send(rnd_cmd(KIND_TICK));
			endcase
		end
		if ($urandom_range(0, 1)) begin
			send(mk(KIND_REL, $urandom_range(0, 12) - 6, $urandom, $urandom_range(0, 1)));
			ticks_until_idle(300);
		end
		settle();
	endtask

	task automatic noise_seq();
		cmd_t c;
		repeat ($urandom_range(1, 4)) begin
			c = rnd_cmd($urandom_range(0, 7));
			if (c.kind == KIND_RUN || c.kind == KIND_SET_SPEED) c.speed = fast_speed();
			send(c);
		end
		repeat ($urandom_range(0, 6)) send(rnd_cmd(KIND_TICK));
		settle();
	endtask

	task automatic clamp_seq();
		// slow setting is overwritten before any period can pick it up
		send(mk(KIND_SET_SPEED, $urandom, $urandom_range(0, 40), $urandom_range(0, 1)));
		send(mk(KIND_SET_SPEED, $urandom, $urandom_range(249990, 262143), $urandom_range(0, 1)));
		repeat ($urandom_range(1, 4)) send(rnd_cmd(KIND_TICK));
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) trk.check_status(res_ch.data);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int  cfg_phase;
		bit  hold_done;
		trk          = new();
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		idle_on      = 1'b0;
		hold_req     = 1'b0;
		cfg_phase    = 0;
		hold_done    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_invert(1'b0);

		send(rnd_cmd(KIND_TICK));
		send(rnd_cmd(KIND_STOP));
		send(rnd_cmd(KIND_UNUSED));
		send(mk(KIND_SET_SPEED, $urandom, '0, 1'b0));
		send(mk(KIND_SET_SPEED, $urandom, '1, 1'b1));
		send(mk(KIND_SET_POS, 32'h7FFF_FFFF, '0, 1'b0));
		send(mk(KIND_REL, 32'h0, '1, 1'b1));
		send(mk(KIND_ABS, 32'h7FFF_FFFF, '0, 1'b0));
		// forward move across the positive wrap
		send(mk(KIND_REL, 32'd2, '1, 1'b1));
		ticks_until_idle(20);
		send(mk(KIND_REL, 32'h8000_0000, '0, 1'b1));
		send(rnd_cmd(KIND_TICK));
		send(mk(KIND_SET_POS, 32'hFFFF_FFFF, '1, 1'b0));
		send(rnd_cmd(KIND_TICK));
		send(mk(KIND_RUN, 32'h7FFF_FFFF, SPEED_MAX, 1'b0));
		send(rnd_cmd(KIND_TICK));
		send(mk(KIND_RUN, 32'h0, '1, 1'b1));
		send(rnd_cmd(KIND_TICK));
		send(rnd_cmd(KIND_STOP));
		ticks_until_idle(20);

		set_invert(1'b1);
		while (sent < N_ITEMS) begin
			idle_on = (sent < QUIET_AT) && ($urandom_range(0, 3) != 0);
			if (!hold_done && sent >= HOLD_AT) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (cfg_phase < 3 && sent >= 450 * (cfg_phase + 1)) begin
				set_invert(!trk.invert_dir);
				cfg_phase++;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: move_seq();
				6, 7:             run_seq();
				8:                noise_seq();
				default:          clamp_seq();
			endcase
		end

		idle_on = 1'b0;
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (trk.errors == 0 && trk.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== step_dir_pulse_generator_unit.f =====
hw/rtl/sdpg_pkg.sv
hw/rtl/sdpg_stream_if.sv
hw/rtl/sdpg_front.sv
hw/rtl/sdpg_queue.sv
hw/rtl/sdpg_back.sv
hw/rtl/step_dir_pulse_generator_unit.sv
verif/step_dir_pulse_generator_unit_tb.sv
